// ===== rtl/lcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared sizes and the token type that moves along the cell chain.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int MAX_LEN     = 64;
    localparam int IDX_W       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W       = $clog2(MAX_LEN + 1);
    localparam int DP_W        = CNT_W;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 7;
    localparam int OUT_TDATA_W = 8;

    typedef struct packed {
        logic             vld;
        logic             upd;
        logic             fin;
        logic             take;
        logic [SYM_W-1:0] sym;
    } lcs_tok_t;

endpackage
`default_nettype wire

// ===== rtl/lcs_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_cell
// One position of the first string: holds its symbol and its row value,
// updates the value for each passing symbol flagged for update and hands the wavefront on.
// ----------------------------------------------------------------------------
module lcs_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      clr,
    input  wire logic [lcs_pkg::IDX_W-1:0] idx,
    input  wire logic                      wr_en,
    input  wire logic [lcs_pkg::IDX_W-1:0] wr_idx,
    input  wire logic [lcs_pkg::SYM_W-1:0] wr_sym,
    input  wire logic [lcs_pkg::CNT_W-1:0] first_len,
    input  wire lcs_pkg::lcs_tok_t         tok_in,
    input  wire logic [lcs_pkg::DP_W-1:0]  left_in,
    input  wire logic [lcs_pkg::DP_W-1:0]  diag_in,
    input  wire logic [lcs_pkg::DP_W-1:0]  res_in,
    output lcs_pkg::lcs_tok_t              tok_out,
    output logic [lcs_pkg::DP_W-1:0]       left_out,
    output logic [lcs_pkg::DP_W-1:0]       diag_out,
    output logic [lcs_pkg::DP_W-1:0]       res_out
);
    import lcs_pkg::*;

    logic [SYM_W-1:0] sym_reg;
    logic [DP_W-1:0]  dp_reg;
    logic [DP_W-1:0]  dp_next;
    logic [DP_W-1:0]  best;
    logic             tail;
    lcs_tok_t         tok_reg;
    logic [DP_W-1:0]  left_reg;
    logic [DP_W-1:0]  diag_reg;
    logic [DP_W-1:0]  res_reg;
    logic [DP_W-1:0]  res_next;

    assign tail = (first_len == (CNT_W'(idx) + CNT_W'(1)));
    assign best = (left_in > dp_reg) ? left_in : dp_reg;

    always_comb begin
        dp_next = dp_reg;
        if (tok_in.vld && tok_in.upd) begin
            dp_next = (sym_reg == tok_in.sym) ? (diag_in + DP_W'(1)) : best;
        end
        res_next = res_in;
        if (tok_in.vld && tok_in.fin && tok_in.take && tail) begin
            res_next = dp_next;
        end
    end

    // store the symbol of this position
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_idx == idx)) begin
            sym_reg <= wr_sym;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            dp_reg <= '0;
        end else if (en) begin
            dp_reg <= dp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
        end else if (en) begin
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            left_reg     <= dp_next;
            diag_reg     <= dp_reg;
            res_reg      <= res_next;
        end
    end

    assign tok_out  = tok_reg;
    assign left_out = left_reg;
    assign diag_out = diag_reg;
    assign res_out  = res_reg;

endmodule
`default_nettype wire

// ===== rtl/lcs_length.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_length
// Longest common subsequence length of two byte strings on a chain of cells.
// ----------------------------------------------------------------------------
//  channel | dir | tdata             | tuser                        | tlast
//  s_      | in  | [7:0] symbol      | [0] string_select [1] empty  | is_last
//  m_      | out | [6:0] lcs_length  | [0] too_long                 | -
//
//  One item is taken per cycle, for either string, while s_tready is high.
//  The last item of the second string runs down the cell chain; the result
//  reaches the output register when that item leaves the last cell.
//  s_tready stays low from that item until the result is registered.
//  A stalled output holds the chain while the final item waits at its end.
//  Reset clears all control state and the row values.
// ----------------------------------------------------------------------------
module lcs_length (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] symbol
    input  wire logic [1:0] s_tuser,   // [0] string_select, [1] is_empty
    input  wire logic       s_tlast,   // is_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [6:0] lcs_length, [7] zero
    output logic [0:0]      m_tuser    // [0] too_long
);
    import lcs_pkg::*;

    logic             acc;
    logic             sel;
    logic             empty;
    logic             last;
    logic             en;
    logic             tok_exit;
    logic             capture;

    logic [CNT_W-1:0] first_len_reg,  first_len_next;
    logic [CNT_W-1:0] len_eff;
    logic             closed_reg,     closed_next;
    logic             started_reg,    started_next;
    logic             ovf_reg,        ovf_next;
    logic [CNT_W-1:0] sec_cnt_reg,    sec_cnt_next;
    logic             drain_reg,      drain_next;
    logic             wr_en;

    logic             m_valid_reg;
    logic [LEN_W-1:0] m_len_reg;
    logic             m_long_reg;

    lcs_tok_t         tok   [MAX_LEN+1];
    logic [DP_W-1:0]  left  [MAX_LEN+1];
    logic [DP_W-1:0]  diag  [MAX_LEN+1];
    logic [DP_W-1:0]  res   [MAX_LEN+1];

    assign sel   = s_tuser[0];
    assign empty = s_tuser[1];
    assign last  = s_tlast;

    assign s_tready = !drain_reg;
    assign acc      = s_tvalid && s_tready;

    assign tok_exit = tok[MAX_LEN].vld && tok[MAX_LEN].fin;
    assign en       = !(tok_exit && m_valid_reg && !m_tready);
    assign capture  = tok_exit && en;

    assign len_eff = closed_reg ? '0 : first_len_reg;
    assign wr_en   = acc && !sel && !started_reg && !empty
                     && (len_eff < CNT_W'(MAX_LEN));

    // inject second-string items at the head of the chain
    always_comb begin
        tok[0].vld  = acc && sel;
        tok[0].upd  = !empty && (sec_cnt_reg < CNT_W'(MAX_LEN));
        tok[0].fin  = empty || last;
        tok[0].take = !empty;
        tok[0].sym  = s_tdata;
        left[0]     = '0;
        diag[0]     = '0;
        res[0]      = '0;
    end

    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        lcs_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .clr       (capture),
            .idx       (IDX_W'(i)),
            .wr_en     (wr_en),
            .wr_idx    (len_eff[IDX_W-1:0]),
            .wr_sym    (s_tdata),
            .first_len (first_len_reg),
            .tok_in    (tok[i]),
            .left_in   (left[i]),
            .diag_in   (diag[i]),
            .res_in    (res[i]),
            .tok_out   (tok[i+1]),
            .left_out  (left[i+1]),
            .diag_out  (diag[i+1]),
            .res_out   (res[i+1])
        );
    end

    always_comb begin
        first_len_next = first_len_reg;
        closed_next    = closed_reg;
        started_next   = started_reg;
        ovf_next       = ovf_reg;
        sec_cnt_next   = sec_cnt_reg;
        drain_next     = drain_reg;
        if (capture) begin
            first_len_next = '0;
            closed_next    = 1'b0;
            started_next   = 1'b0;
            ovf_next       = 1'b0;
            sec_cnt_next   = '0;
            drain_next     = 1'b0;
        end else if (acc && !sel) begin
            if (!started_reg) begin
                if (closed_reg) begin
                    ovf_next = 1'b0;
                end
                closed_next    = 1'b0;
                first_len_next = len_eff;
                if (empty) begin
                    first_len_next = '0;
                    closed_next    = 1'b1;
                end else begin
                    if (len_eff < CNT_W'(MAX_LEN)) begin
                        first_len_next = len_eff + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (last) begin
                        closed_next = 1'b1;
                    end
                end
            end
        end else if (acc && sel) begin
            started_next = 1'b1;
            if (!empty) begin
                if (sec_cnt_reg < CNT_W'(MAX_LEN)) begin
                    sec_cnt_next = sec_cnt_reg + CNT_W'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end
            if (empty || last) begin
                drain_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_len_reg <= '0;
            closed_reg    <= 1'b0;
            started_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            sec_cnt_reg   <= '0;
            drain_reg     <= 1'b0;
        end else begin
            first_len_reg <= first_len_next;
            closed_reg    <= closed_next;
            started_reg   <= started_next;
            ovf_reg       <= ovf_next;
            sec_cnt_reg   <= sec_cnt_next;
            drain_reg     <= drain_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (capture) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            m_len_reg  <= LEN_W'(res[MAX_LEN]);
            m_long_reg <= ovf_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = OUT_TDATA_W'(m_len_reg);
    assign m_tuser[0] = m_long_reg;

    a_first_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        first_len_reg <= CNT_W'(MAX_LEN))
        else $error("first string length past capacity");

    a_sec_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sec_cnt_reg <= CNT_W'(MAX_LEN))
        else $error("second string count past capacity");

    a_exit_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_exit |-> drain_reg)
        else $error("final item left the chain outside a drain");

    a_capture_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        capture |=> (m_tvalid && !drain_reg && (first_len_reg == '0)))
        else $error("result capture did not end the pair");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lcs_length. String pairs are streamed in, both
// directed corner cases and random pairs of short and overlong strings. A
// behavioral copy of the row-update algorithm predicts each length and
// too_long flag, and every result item is compared against it.
// ----------------------------------------------------------------------------
module tb;

    import lcs_pkg::*;

    localparam bit SEL_A          = 1'b0;
    localparam bit SEL_B          = 1'b1;
    localparam int IDLE_PCT       = 29;
    localparam int RX_HOLD_AT     = 8;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT    = 4000;
    localparam int RANDOM_ITEMS   = 900;
    localparam int RANDOM_PAIRS   = 40;

    typedef struct packed {
        logic             sel;
        logic [SYM_W-1:0] sym;
        logic             empty;
        logic             last;
    } lcs_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             too_long;
    } lcs_res_t;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic [1:0] s_tuser  = '0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;

    lcs_item_t  sym_pending[$];
    lcs_res_t   lcs_expected[$];
    int         items_queued = 0;
    int         items_taken  = 0;
    int         items_sent   = 0;
    int         lengths_seen = 0;
    int         lcs_pairs    = 0;
    int         errors       = 0;
    int         stall_cycles = 0;
    int         hold_left    = 0;
    bit         hold_done    = 1'b0;
    bit         s_took       = 1'b0;

    // predictor state
    logic [SYM_W-1:0] a_str [MAX_LEN];
    logic [DP_W-1:0]  lcs_row [MAX_LEN];
    int               a_len;
    int               b_cnt;
    bit               a_closed;
    bit               b_started;
    bit               ovf_seen;

    lcs_length i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic void pair_clear();
        for (int i = 0; i < MAX_LEN; i++) begin
            a_str[i]   = '0;
            lcs_row[i] = '0;
        end
        a_len     = 0;
        b_cnt     = 0;
        a_closed  = 1'b0;
        b_started = 1'b0;
        ovf_seen  = 1'b0;
    endfunction

    function automatic void lcs_track(input lcs_item_t it, output bit emits,
                                      output lcs_res_t res);
        int diag;
        int left;
        int up;
        int val;
        emits = 1'b0;
        res   = '0;
        if (it.sel == SEL_A) begin
            if (b_started)
                return;
            if (a_closed) begin
                a_len    = 0;
                ovf_seen = 1'b0;
                a_closed = 1'b0;
            end
            if (it.empty) begin
                a_len    = 0;
                a_closed = 1'b1;
                return;
            end
            if (a_len < MAX_LEN) begin
                a_str[a_len] = it.sym;
                a_len++;
            end else begin
                ovf_seen = 1'b1;
            end
            if (it.last)
                a_closed = 1'b1;
            return;
        end
        b_started = 1'b1;
        if (it.empty) begin
            emits        = 1'b1;
            res.too_long = ovf_seen;
            pair_clear();
            return;
        end
        if (b_cnt < MAX_LEN) begin
            diag = 0;
            left = 0;
            for (int i = 0; i < a_len; i++) begin
                up   = lcs_row[i];
                val  = (a_str[i] == it.sym) ? diag + 1 : ((left > up) ? left : up);
                diag = up;
                lcs_row[i] = DP_W'(val);
                left = val;
            end
            b_cnt++;
        end else begin
            ovf_seen = 1'b1;
        end
        if (it.last) begin
            emits        = 1'b1;
            res.len      = (a_len > 0) ? lcs_row[a_len-1][LEN_W-1:0] : '0;
            res.too_long = ovf_seen;
            pair_clear();
        end
    endfunction

    function automatic void queue_item(bit sel, logic [7:0] sym, bit empty, bit last);
        lcs_item_t it;
        it.sel   = sel;
        it.sym   = sym;
        it.empty = empty;
        it.last  = last;
        sym_pending.push_back(it);
        items_queued++;
    endfunction

    // width 0 draws full bytes, otherwise symbols come from a small alphabet
    function automatic void queue_string(bit sel, int n, int width, logic [7:0] base,
                                         bit closed);
        logic [7:0] sym;
        for (int k = 0; k < n; k++) begin
            sym = (width == 0) ? 8'($urandom) : base + 8'($urandom_range(width - 1, 0));
            queue_item(sel, sym, 1'b0, closed && (k == n - 1));
        end
        if (n == 0 && closed)
            queue_item(sel, 8'($urandom), 1'b1, 1'($urandom_range(1, 0)));
    endfunction

    function automatic int pick_len();
        return ($urandom_range(99, 0) < 12) ? $urandom_range(72, 60) : $urandom_range(10, 0);
    endfunction

    function automatic void queue_random_pair();
        int         kind;
        int         width;
        int         n_a;
        int         n_b;
        int         cut;
        logic [7:0] base;
        kind  = $urandom_range(99, 0);
        width = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(4, 1);
        base  = 8'($urandom);
        n_a   = pick_len();
        n_b   = pick_len();
        if (kind < 8) begin
            queue_item(1'($urandom_range(1, 0)), 8'($urandom),
                       1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
            return;
        end
        lcs_pairs++;
        if (kind < 18)
            queue_string(SEL_A, pick_len(), width, base, 1'b1);
        queue_string(SEL_A, n_a, width, base, !(kind >= 18 && kind < 26));
        if (kind >= 26 && kind < 36 && n_b > 1) begin
            cut = $urandom_range(n_b - 1, 1);
            queue_string(SEL_B, cut, width, base, 1'b0);
            queue_item(SEL_A, 8'($urandom), 1'($urandom_range(1, 0)),
                       1'($urandom_range(1, 0)));
            queue_string(SEL_B, n_b - cut, width, base, 1'b1);
        end else if (kind >= 36 && kind < 44) begin
            queue_string(SEL_B, n_b, width, base, 1'b0);
            queue_item(SEL_B, 8'($urandom), 1'b1, 1'($urandom_range(1, 0)));
        end else begin
            queue_string(SEL_B, n_b, width, base, 1'b1);
        end
    endfunction

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (items_taken != items_queued || lcs_expected.size() != 0);
    endtask

    function automatic void flag_error(string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    // drive input items
    always @(negedge aclk) begin
        lcs_item_t nx;
        if (aresetn && !(s_tvalid && !s_took)) begin
            if (sym_pending.size() > 0 &&
                ((items_sent >= 400 && items_sent < 600) ||
                 $urandom_range(99, 0) >= IDLE_PCT)) begin
                nx = sym_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nx.sym;
                s_tuser  <= {nx.empty, nx.sel};
                s_tlast  <= nx.last;
                items_sent++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // drive result ready, with one long hold-off
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!hold_done && lengths_seen == RX_HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (lengths_seen >= 15 && lengths_seen < 25) ||
                            ($urandom_range(99, 0) >= IDLE_PCT);
            end
        end
    end

    // predict on accepted items, check result items, watch for a hang
    always @(posedge aclk) begin
        lcs_item_t it;
        lcs_res_t  want;
        lcs_res_t  res;
        bit        emits;
        if (aresetn) begin
            s_took = s_tvalid && s_tready;
            if (s_took) begin
                it.sel   = s_tuser[0];
                it.empty = s_tuser[1];
                it.sym   = s_tdata;
                it.last  = s_tlast;
                items_taken++;
                lcs_track(it, emits, res);
                if (emits)
                    lcs_expected.push_back(res);
            end
            if (m_tvalid && m_tready) begin
                lengths_seen++;
                if (lcs_expected.size() == 0) begin
                    flag_error($sformatf("unexpected result: lcs_length=%0d too_long=%0b",
                                         m_tdata[LEN_W-1:0], m_tuser[0]));
                end else begin
                    want = lcs_expected.pop_front();
                    if (m_tdata[LEN_W-1:0] !== want.len || m_tuser[0] !== want.too_long)
                        flag_error($sformatf(
                            "result %0d: exp lcs_length=%0d too_long=%0b, got %0d/%0b",
                            lengths_seen, want.len, want.too_long,
                            m_tdata[LEN_W-1:0], m_tuser[0]));
                end
            end
            stall_cycles = (s_took || (m_tvalid && m_tready)) ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        pair_clear();
        // second string with no first string
        queue_item(SEL_B, 8'h00, 1'b0, 1'b1);
        // empty first, then empty second
        queue_item(SEL_A, 8'hFF, 1'b1, 1'b0);
        queue_item(SEL_B, 8'h00, 1'b1, 1'b1);
        // single matching symbol
        queue_item(SEL_A, 8'hFF, 1'b0, 1'b1);
        queue_item(SEL_B, 8'hFF, 1'b0, 1'b1);
        // closed first string replaced, first symbol ignored during second
        queue_item(SEL_A, 8'h11, 1'b0, 1'b1);
        queue_item(SEL_A, 8'h22, 1'b0, 1'b0);
        queue_item(SEL_A, 8'h33, 1'b0, 1'b1);
        queue_item(SEL_B, 8'h22, 1'b0, 1'b0);
        queue_item(SEL_A, 8'h33, 1'b0, 1'b1);
        queue_item(SEL_B, 8'h33, 1'b0, 1'b1);
        // second string ended by an empty item
        queue_item(SEL_A, 8'hAA, 1'b0, 1'b1);
        queue_item(SEL_B, 8'hAA, 1'b0, 1'b0);
        queue_item(SEL_B, 8'h5A, 1'b1, 1'b0);
        // empty item discards loaded first-string symbols
        queue_item(SEL_A, 8'h01, 1'b0, 1'b0);
        queue_item(SEL_A, 8'h02, 1'b0, 1'b0);
        queue_item(SEL_A, 8'h80, 1'b1, 1'b1);
        queue_item(SEL_B, 8'h01, 1'b0, 1'b1);
        // crossed order gives one
        queue_item(SEL_A, 8'h7F, 1'b0, 1'b0);
        queue_item(SEL_A, 8'h80, 1'b0, 1'b1);
        queue_item(SEL_B, 8'h80, 1'b0, 1'b0);
        queue_item(SEL_B, 8'h7F, 1'b0, 1'b1);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait_drained();

        while (lcs_pairs < RANDOM_PAIRS / 2)
            queue_random_pair();
        wait_drained();
        while (items_queued < RANDOM_ITEMS + 22 || lcs_pairs < RANDOM_PAIRS)
            queue_random_pair();
        wait_drained();

        repeat (MAX_LEN + 16) @(negedge aclk);
        if (lcs_expected.size() != 0)
            flag_error($sformatf("%0d results never arrived", lcs_expected.size()));
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
